>>> hdl/ins_sort_pkg.sv
// Package with the transaction types and controller interface types of the insertion sorter.
package ins_sort_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic last_one;
  } dp_status_t;

endpackage

>>> hdl/ins_sort_dp.sv
// Datapath of the insertion sorter: compare-and-shift chain, run count and overflow flag.
module ins_sort_dp import ins_sort_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic signed [31:0] value,
  output dp_status_t         status,
  output out_item_t          result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] store [DEPTH];
  logic signed [31:0] store_next [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               overflow_seen;
  logic [DEPTH-1:0]   gt;
  logic               full;
  logic               insert_ok;

  assign full      = (count == CW'(DEPTH));
  assign insert_ok = cmd.insert && !full;

  // Each cell compares the new value with its own entry. Since the chain is sorted, the
  // cells that hold a larger value form a contiguous upper block, which moves up one place.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               prev_gt;
    logic signed [31:0] prev;
    logic signed [31:0] upper;
    logic               place;

    assign gt[i] = (CW'(i) < count) && (store[i] > value);

    if (i == 0) begin : g_first
      assign prev_gt = 1'b0;
      assign prev    = value;
    end else begin : g_rest
      assign prev_gt = gt[i-1];
      assign prev    = store[i-1];
    end

    if (i == DEPTH - 1) begin : g_top
      assign upper = store[i];
    end else begin : g_mid
      assign upper = store[i+1];
    end

    assign place = !prev_gt && (gt[i] || (CW'(i) == count));

    always_comb begin
      store_next[i] = store[i];
      if (cmd.shift_out) begin
        store_next[i] = upper;
      end else if (insert_ok) begin
        if (prev_gt) begin
          store_next[i] = prev;
        end else if (place) begin
          store_next[i] = value;
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.clear) begin
      count_next = '0;
    end else if (cmd.shift_out) begin
      count_next = count - CW'(1);
    end else if (insert_ok) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      store[i] <= store_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.clear) begin
        overflow_seen <= 1'b0;
      end else if (cmd.insert && full) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  assign status.last_one     = (count == CW'(1));
  assign result.sorted_value = store[0];
  assign result.last_out     = (count == CW'(1));
  assign result.overflow     = overflow_seen;

endmodule

>>> hdl/ins_sort_ctrl.sv
// Controller of the insertion sorter: collects a run, then drains it in order.
module ins_sort_ctrl import ins_sort_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  input  logic       out_ready,
  input  dp_status_t status,
  output logic       in_ready,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (in_valid && in_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready && status.last_one) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state)
      ST_COLLECT: begin
        in_ready   = 1'b1;
        cmd.insert = in_valid;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.shift_out = out_ready;
        cmd.clear     = out_ready && status.last_one;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/insertion_sorter.sv
// Top level of the insertion sorter: controller and sorting datapath.
//
// Input channel (in_valid/in_ready/in_item): one signed value per transaction, with
// last_in set on the final value of a run. While a run is being collected, one value
// is taken every cycle; each is inserted into a chain of DEPTH compare-and-shift cells
// in the cycle it is accepted. Values beyond DEPTH in a run are dropped and the run's
// results carry overflow.
// Output channel (out_valid/out_ready/out_item): after the last value is accepted, the
// first result appears in the next cycle, and the stored values follow in ascending order,
// one per cycle while out_ready is high; last_out marks the final one. Equal values keep
// their arrival order.
// A run of N values leaves N stored values or, for an overflowing run, DEPTH; input is
// not accepted while results are being drained, since the drain shifts the same cell
// chain.
// When the receiver stalls, the current result holds until it is taken.
// Reset (rst, synchronous) empties the run and clears the overflow flag.
module insertion_sorter import ins_sort_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ins_sort_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_item.last_in),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ins_sort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .value  (in_item.value),
    .status (status),
    .result (out_item)
  );

endmodule

>>> bench/insertion_sorter_tb.sv
// Self-checking testbench for the insertion sorter: directed and random runs with idle gaps, checked in order.
`timescale 1ns / 100ps

module insertion_sorter_tb;
  import ins_sort_pkg::*;

  localparam int DEPTH        = 8;
  localparam int ITEM_TARGET  = 480;
  localparam int LONG_HOLD    = 150;
  localparam int HOLD_AT_ITEM = 200;
  localparam int IDLE_LIMIT   = 1000;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    in_item_t item;
    bit       wait_for_drain;
  } feed_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  feed_t     feed_q[$];
  out_item_t sorted_q[$];

  // Shadow copy of the run being collected.
  logic signed [31:0] run_store[DEPTH];
  int  run_len = 0;
  bit  run_dropped = 1'b0;

  int  items_sent = 0;
  int  fail_count = 0;
  int  send_gap = 0;
  int  send_burst = 0;
  int  take_gap = 0;
  int  take_burst = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  idle_cycles = 0;

  insertion_sorter #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly no gap or a short one, a few long ones, and now and then a stretch with none.
  function automatic int pick_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Inserts one value into the shadow run and, on the last one, queues the sorted run.
  function automatic void insert_and_emit(in_item_t it);
    int pos;
    out_item_t res;
    if (run_len < DEPTH) begin
      pos = run_len;
      while (pos > 0 && run_store[pos - 1] > it.value) begin
        run_store[pos] = run_store[pos - 1];
        pos--;
      end
      run_store[pos] = it.value;
      run_len++;
    end else begin
      run_dropped = 1'b1;
    end
    if (it.last_in) begin
      for (int k = 0; k < run_len; k++) begin
        res.sorted_value = run_store[k];
        res.last_out     = (k == run_len - 1);
        res.overflow     = run_dropped;
        sorted_q.push_back(res);
      end
      run_len     = 0;
      run_dropped = 1'b0;
    end
  endfunction

  function automatic void add_item(logic signed [31:0] v, bit last, bit drain = 1'b0);
    feed_t f;
    f.item.value    = v;
    f.item.last_in  = last;
    f.wait_for_drain = drain;
    feed_q.push_back(f);
  endfunction

  function automatic logic signed [31:0] pick_value(int style);
    logic signed [31:0] v;
    case (style)
      0: v = $urandom;
      1: v = $signed($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 5))
          0: v = 32'sh8000_0000;
          1: v = 32'sh8000_0001;
          2: v = 32'sh7FFF_FFFF;
          3: v = 32'sh7FFF_FFFE;
          4: v = 32'sh0000_0000;
          default: v = -32'sd1;
        endcase
      end
      default: v = pick_value($urandom_range(0, 2));
    endcase
    return v;
  endfunction

  // Driver: takes the next pending item when the input slot is free and any random gap has passed.
  always @(posedge clk) begin : drive
    feed_t nxt;
    bit give;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        insert_and_emit(in_item);
        items_sent++;
        send_gap = pick_gap(send_burst);
      end
      if (!in_valid || in_ready) begin
        give = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (feed_q.size() > 0 &&
                     !(feed_q[0].wait_for_drain && sorted_q.size() > 0)) begin
          nxt  = feed_q.pop_front();
          give = 1'b1;
        end
        in_valid <= give;
        if (give) in_item <= nxt.item;
      end
    end
  end

  // Monitor: checks each result against the oldest expectation and paces out_ready.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: sorted_value %0d", out_item.sorted_value);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (out_item.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   out_item.sorted_value);
            fail_count++;
          end
          if (out_item.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_item.last_out);
            fail_count++;
          end
          if (out_item.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_item.overflow);
            fail_count++;
          end
        end
        take_gap = pick_gap(take_burst);
      end else if (take_gap == 0 && $urandom_range(0, 9) == 0) begin
        take_gap = pick_gap(take_burst);
      end
      // One long hold-off while the sender keeps offering, so the sorter backs up.
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int run_n;
    int style;
    int r;
    bit drain_done;

    // Single value at the top of the range.
    add_item(32'sh7FFF_FFFF, 1'b1);
    // Extremes of the signed range mixed with zero and minus one.
    add_item(32'sh8000_0000, 1'b0);
    add_item(32'sh7FFF_FFFF, 1'b0);
    add_item(32'sh0000_0000, 1'b0);
    add_item(-32'sd1, 1'b1);
    // Ties must keep arrival order.
    add_item(-32'sd5, 1'b0);
    add_item(32'sd5, 1'b0);
    add_item(32'sd5, 1'b1);
    // A full store in descending order: every insert shifts the whole run.
    for (int i = 0; i < DEPTH; i++) add_item(DEPTH - 1 - i, i == DEPTH - 1);
    // One value too many, and the dropped one is the last of the run.
    for (int i = 0; i < DEPTH + 1; i++) add_item(pick_value(0), i == DEPTH);

    drain_done = 1'b0;
    while (feed_q.size() < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) run_n = $urandom_range(DEPTH + 1, DEPTH + 4);
      else if (r < 18) run_n = DEPTH;
      else run_n = $urandom_range(1, DEPTH);
      style = $urandom_range(0, 3);
      for (int i = 0; i < run_n; i++) begin
        // The sender waits for all results once right after the directed runs
        // and once late in the random part.
        add_item(pick_value(style), i == run_n - 1,
                 i == 0 && (feed_q.size() == 25 ||
                            (!drain_done && feed_q.size() >= 360)));
        if (i == 0 && feed_q.size() > 360) drain_done = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() > 0 || in_valid || sorted_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
